// ----- hdl/lpqrg_pkg.sv -----
// Shared types, widths and register codes for the lidar quadrilateral ROI gate.
// No dependencies; every other file refers to this package by scoped names.
package lpqrg_pkg;

   localparam int COORD_BITS = 32;
   localparam int INDEX_BITS = 20;
   localparam int HEIGHT_BITS = 16;
   localparam int WORD_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam int IN_BITS = 2 * COORD_BITS + HEIGHT_BITS + INDEX_BITS;
   localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
   localparam int OUT_BITS = 2 * COORD_BITS + HEIGHT_BITS + INDEX_BITS;
   localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

   // Stages from input register to result register
   localparam int PIPE_DEPTH = 4;
   localparam int PIPE_CNT_BITS = $clog2(PIPE_DEPTH + 1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;
   typedef logic signed [HEIGHT_BITS-1:0] height_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CORNER_ONE   = 3'd0,
      REG_CORNER_TWO   = 3'd1,
      REG_CORNER_THREE = 3'd2,
      REG_CORNER_FOUR  = 3'd3,
      REG_Z_FLOOR      = 3'd4,
      REG_Z_CEILING    = 3'd5,
      REG_VEHICLE_POS  = 3'd6
   } reg_index_type;

   // Region setup as seen by the datapath, with derived bounds and edge vectors
   typedef struct packed {
      coord_type [3:0] corner_x;
      coord_type [3:0] corner_y;
      diff_type [3:0]  edge_x;
      diff_type [3:0]  edge_y;
      coord_type       min_x;
      coord_type       max_x;
      coord_type       min_y;
      coord_type       max_y;
      height_type      z_floor;
      height_type      z_ceiling;
      coord_type       veh_x;
      coord_type       veh_y;
   } cfg_type;

   // Sign-extend one packed register word to a coordinate
   function automatic coord_type word_to_coord(input logic [WORD_BITS-1:0] w);
      logic signed [WORD_BITS-1:0] ws;
      ws = signed'(w);
      return COORD_BITS'(ws);
   endfunction

endpackage

// ----- hdl/lpqrg_csr.sv -----
// Configuration registers of the ROI gate plus bounds and edge vectors derived from them.
// Depends on lpqrg_pkg.
module lpqrg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lpqrg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lpqrg_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output lpqrg_pkg::cfg_type                   cfg
);

   lpqrg_pkg::coord_type corner_x_ff [4];
   lpqrg_pkg::coord_type corner_y_ff [4];
   lpqrg_pkg::coord_type corner_x_in [4];
   lpqrg_pkg::coord_type corner_y_in [4];
   lpqrg_pkg::height_type z_floor_ff, z_floor_in;
   lpqrg_pkg::height_type z_ceiling_ff, z_ceiling_in;
   lpqrg_pkg::coord_type veh_x_ff, veh_x_in;
   lpqrg_pkg::coord_type veh_y_ff, veh_y_in;

   lpqrg_pkg::diff_type edge_x_ff [4];
   lpqrg_pkg::diff_type edge_y_ff [4];
   lpqrg_pkg::diff_type edge_x_in [4];
   lpqrg_pkg::diff_type edge_y_in [4];
   lpqrg_pkg::coord_type min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   lpqrg_pkg::coord_type min_x_in, max_x_in, min_y_in, max_y_in;

   function automatic lpqrg_pkg::coord_type min2(input lpqrg_pkg::coord_type a,
                                                input lpqrg_pkg::coord_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic lpqrg_pkg::coord_type max2(input lpqrg_pkg::coord_type a,
                                                input lpqrg_pkg::coord_type b);
      return (a > b) ? a : b;
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         corner_x_in[i] = corner_x_ff[i];
         corner_y_in[i] = corner_y_ff[i];
      end
      z_floor_in = z_floor_ff;
      z_ceiling_in = z_ceiling_ff;
      veh_x_in = veh_x_ff;
      veh_y_in = veh_y_ff;
      if (csr_valid) begin
         unique case (csr_index) inside
            lpqrg_pkg::REG_CORNER_ONE, lpqrg_pkg::REG_CORNER_TWO,
            lpqrg_pkg::REG_CORNER_THREE, lpqrg_pkg::REG_CORNER_FOUR: begin
               corner_x_in[csr_index[1:0]] =
                  lpqrg_pkg::word_to_coord(csr_data[lpqrg_pkg::WORD_BITS-1:0]);
               corner_y_in[csr_index[1:0]] =
                  lpqrg_pkg::word_to_coord(csr_data[32 +: lpqrg_pkg::WORD_BITS]);
            end
            lpqrg_pkg::REG_Z_FLOOR: begin
               z_floor_in = signed'(csr_data[lpqrg_pkg::HEIGHT_BITS-1:0]);
            end
            lpqrg_pkg::REG_Z_CEILING: begin
               z_ceiling_in = signed'(csr_data[lpqrg_pkg::HEIGHT_BITS-1:0]);
            end
            lpqrg_pkg::REG_VEHICLE_POS: begin
               veh_x_in = lpqrg_pkg::word_to_coord(csr_data[lpqrg_pkg::WORD_BITS-1:0]);
               veh_y_in = lpqrg_pkg::word_to_coord(csr_data[32 +: lpqrg_pkg::WORD_BITS]);
            end
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   // Derived values are registered from the stored corners and follow them in the next cycle
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         edge_x_in[i] = lpqrg_pkg::DIFF_BITS'(corner_x_ff[(i + 1) % 4])
                      - lpqrg_pkg::DIFF_BITS'(corner_x_ff[i]);
         edge_y_in[i] = lpqrg_pkg::DIFF_BITS'(corner_y_ff[(i + 1) % 4])
                      - lpqrg_pkg::DIFF_BITS'(corner_y_ff[i]);
      end
      min_x_in = min2(min2(corner_x_ff[0], corner_x_ff[1]), min2(corner_x_ff[2], corner_x_ff[3]));
      max_x_in = max2(max2(corner_x_ff[0], corner_x_ff[1]), max2(corner_x_ff[2], corner_x_ff[3]));
      min_y_in = min2(min2(corner_y_ff[0], corner_y_ff[1]), min2(corner_y_ff[2], corner_y_ff[3]));
      max_y_in = max2(max2(corner_y_ff[0], corner_y_ff[1]), max2(corner_y_ff[2], corner_y_ff[3]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            corner_x_ff[i] <= '0;
            corner_y_ff[i] <= '0;
            edge_x_ff[i] <= '0;
            edge_y_ff[i] <= '0;
         end
         z_floor_ff <= '0;
         z_ceiling_ff <= '0;
         veh_x_ff <= '0;
         veh_y_ff <= '0;
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
      end else begin
         for (int i = 0; i < 4; i++) begin
            corner_x_ff[i] <= corner_x_in[i];
            corner_y_ff[i] <= corner_y_in[i];
            edge_x_ff[i] <= edge_x_in[i];
            edge_y_ff[i] <= edge_y_in[i];
         end
         z_floor_ff <= z_floor_in;
         z_ceiling_ff <= z_ceiling_in;
         veh_x_ff <= veh_x_in;
         veh_y_ff <= veh_y_in;
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cfg.corner_x[i] = corner_x_ff[i];
         cfg.corner_y[i] = corner_y_ff[i];
         cfg.edge_x[i] = edge_x_ff[i];
         cfg.edge_y[i] = edge_y_ff[i];
      end
      cfg.min_x = min_x_ff;
      cfg.max_x = max_x_ff;
      cfg.min_y = min_y_ff;
      cfg.max_y = max_y_ff;
      cfg.z_floor = z_floor_ff;
      cfg.z_ceiling = z_ceiling_ff;
      cfg.veh_x = veh_x_ff;
      cfg.veh_y = veh_y_ff;
   end

endmodule

// ----- hdl/lidar_point_quad_roi_gate_unit.sv -----
// Top level of the lidar quadrilateral ROI gate: four-stage point pipeline.
// Depends on lpqrg_pkg and lpqrg_csr.
//
//  channel   ports                                   word
//  --------  --------------------------------------  -------------------------------------------
//  req in    req_tvalid req_tready req_tdata         world_x, world_y, height, point_index
//  rsp out   rsp_tvalid rsp_tready rsp_tdata/tuser   local_x, local_y, height_out, index_out/keep
//  csr in    csr_valid csr_ready csr_index csr_data  register write, index 0..6
//
// One point per clock while rsp_tready stays high; a word passes four registers (input
// register, differences, edge multipliers, sign compare) in that order before its result
// is presented. The 33x33 multipliers set the stage split.
// Reset is synchronous and clears the pipeline valid flags and all configuration registers
// to zero. A stalled result holds; earlier stages keep filling bubbles, so req_tready drops
// only when all four stages hold a word. A register write is visible to words accepted at
// a later edge than the write.
module lidar_point_quad_roi_gate_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // world_x [31:0], world_y [63:32], height [79:64], point_index [99:80], zero fill
   input  logic [lpqrg_pkg::IN_TDATA_BITS-1:0]  req_tdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // local_x [31:0], local_y [63:32], height_out [79:64], index_out [99:80], zero fill
   output logic [lpqrg_pkg::OUT_TDATA_BITS-1:0] rsp_tdata,
   // keep [0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpqrg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lpqrg_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int C = lpqrg_pkg::COORD_BITS;
   localparam int D = lpqrg_pkg::DIFF_BITS;
   localparam int P = lpqrg_pkg::PROD_BITS;
   localparam int H = lpqrg_pkg::HEIGHT_BITS;
   localparam int N = lpqrg_pkg::INDEX_BITS;

   lpqrg_pkg::cfg_type cfg;

   lpqrg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Saturate a widened difference back to a coordinate
   function automatic lpqrg_pkg::coord_type sat_coord(input lpqrg_pkg::diff_type d);
      lpqrg_pkg::coord_type r;
      if (d[D-1] != d[D-2]) begin
         r = {d[D-1], {(C - 1){~d[D-1]}}};
      end else begin
         r = d[C-1:0];
      end
      return r;
   endfunction

   logic rdy1, rdy2, rdy3, rdy4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1: input register
   lpqrg_pkg::coord_type  px1_ff, py1_ff;
   lpqrg_pkg::height_type pz1_ff;
   lpqrg_pkg::index_type  idx1_ff;

   // stage 2: offsets, bounding box and height band
   lpqrg_pkg::diff_type   dx2_ff [4];
   lpqrg_pkg::diff_type   dy2_ff [4];
   lpqrg_pkg::diff_type   dx2_in [4];
   lpqrg_pkg::diff_type   dy2_in [4];
   logic                  pass2_ff, pass2_in;
   lpqrg_pkg::coord_type  lx2_ff, ly2_ff, lx2_in, ly2_in;
   lpqrg_pkg::height_type pz2_ff;
   lpqrg_pkg::index_type  idx2_ff;

   // stage 3: edge cross product terms
   lpqrg_pkg::prod_type   pa3_ff [4];
   lpqrg_pkg::prod_type   pb3_ff [4];
   lpqrg_pkg::prod_type   pa3_in [4];
   lpqrg_pkg::prod_type   pb3_in [4];
   logic                  pass3_ff;
   lpqrg_pkg::coord_type  lx3_ff, ly3_ff;
   lpqrg_pkg::height_type pz3_ff;
   lpqrg_pkg::index_type  idx3_ff;

   // stage 4: result register
   logic                  keep4_ff, keep4_in;
   lpqrg_pkg::coord_type  lx4_ff, ly4_ff;
   lpqrg_pkg::height_type pz4_ff;
   lpqrg_pkg::index_type  idx4_ff;

   // A stage may load when it is empty or its word moves on
   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: unpack the word
   always_ff @(posedge clock) begin
      if (rdy1) begin
         px1_ff <= signed'(req_tdata[C-1:0]);
         py1_ff <= signed'(req_tdata[2*C-1:C]);
         pz1_ff <= signed'(req_tdata[2*C+H-1:2*C]);
         idx1_ff <= req_tdata[2*C+H+N-1:2*C+H];
      end
   end

   // Stage 2: point offsets from each corner, box and band tests, vehicle-relative position
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         dx2_in[i] = D'(px1_ff) - D'(signed'(cfg.corner_x[i]));
         dy2_in[i] = D'(py1_ff) - D'(signed'(cfg.corner_y[i]));
      end
      pass2_in = (px1_ff >= cfg.min_x) && (px1_ff <= cfg.max_x)
              && (py1_ff >= cfg.min_y) && (py1_ff <= cfg.max_y)
              && (pz1_ff >= cfg.z_floor) && (pz1_ff <= cfg.z_ceiling);
      lx2_in = sat_coord(D'(px1_ff) - D'(cfg.veh_x));
      ly2_in = sat_coord(D'(py1_ff) - D'(cfg.veh_y));
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         for (int i = 0; i < 4; i++) begin
            dx2_ff[i] <= dx2_in[i];
            dy2_ff[i] <= dy2_in[i];
         end
         pass2_ff <= pass2_in;
         lx2_ff <= lx2_in;
         ly2_ff <= ly2_in;
         pz2_ff <= pz1_ff;
         idx2_ff <= idx1_ff;
      end
   end

   // Stage 3: both terms of each edge cross product, exact
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pa3_in[i] = P'(dx2_ff[i]) * P'(signed'(cfg.edge_y[i]));
         pb3_in[i] = P'(dy2_ff[i]) * P'(signed'(cfg.edge_x[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         for (int i = 0; i < 4; i++) begin
            pa3_ff[i] <= pa3_in[i];
            pb3_ff[i] <= pb3_in[i];
         end
         pass3_ff <= pass2_ff;
         lx3_ff <= lx2_ff;
         ly3_ff <= ly2_ff;
         pz3_ff <= pz2_ff;
         idx3_ff <= idx2_ff;
      end
   end

   // Stage 4: sign of each cross product; a zero product agrees with either side
   always_comb begin
      logic any_neg;
      logic any_pos;
      any_neg = 1'b0;
      any_pos = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (pa3_ff[i] < pb3_ff[i]) any_neg = 1'b1;
         if (pa3_ff[i] > pb3_ff[i]) any_pos = 1'b1;
      end
      keep4_in = pass3_ff && !(any_neg && any_pos);
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         keep4_ff <= keep4_in;
         lx4_ff <= lx3_ff;
         ly4_ff <= ly3_ff;
         pz4_ff <= pz3_ff;
         idx4_ff <= idx3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tuser = keep4_ff;
   assign rsp_tdata = lpqrg_pkg::OUT_TDATA_BITS'({idx4_ff, pz4_ff, ly4_ff, lx4_ff});

endmodule

// ----- hdl/lpqrg_checker.sv -----
// Port-level checker for the lidar ROI gate, bound to the top level.
// Depends on lpqrg_pkg and lidar_point_quad_roi_gate_unit.
module lpqrg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic                                 rsp_tuser,
   input logic [lpqrg_pkg::OUT_TDATA_BITS-1:0] rsp_tdata
);

   logic [lpqrg_pkg::PIPE_CNT_BITS-1:0] open_ff, open_in;
   logic in_acc, out_acc;

   assign in_acc = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   // Track words accepted but not yet delivered
   always_comb begin
      open_in = open_ff;
      if (in_acc && !out_acc) open_in = open_ff + 1'b1;
      if (out_acc && !in_acc) open_in = open_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_ff != '0)
      else $error("result word without an accepted request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      open_ff <= lpqrg_pkg::PIPE_CNT_BITS'(lpqrg_pkg::PIPE_DEPTH))
      else $error("more words in flight than pipeline stages");

   a_full_only: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> open_ff == lpqrg_pkg::PIPE_CNT_BITS'(lpqrg_pkg::PIPE_DEPTH))
      else $error("request stalled while a stage is free");

endmodule

bind lidar_point_quad_roi_gate_unit lpqrg_checker u_lpqrg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/lidar_point_quad_roi_gate_unit_tb.sv -----
// Self-checking bench for the lidar quadrilateral ROI gate: drives point words, predicts keep
// flag and vehicle-relative position per word, and checks every result word in order.
// Depends on lpqrg_pkg and the lidar_point_quad_roi_gate_unit RTL.
module lidar_point_quad_roi_gate_unit_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;
   localparam longint COORD_MAX = (longint'(1) <<< (lpqrg_pkg::COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam longint HEIGHT_MAX = (longint'(1) <<< (lpqrg_pkg::HEIGHT_BITS - 1)) - 1;
   localparam longint HEIGHT_MIN = -HEIGHT_MAX - 1;
   localparam longint INDEX_MAX = (longint'(1) <<< lpqrg_pkg::INDEX_BITS) - 1;
   // Index 7 has no register behind it; writes there must change nothing
   localparam logic [lpqrg_pkg::CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   typedef enum int {
      REGION_CCW,       // convex-ish quad, counter-clockwise corners
      REGION_CW,        // same shape family, clockwise corners
      REGION_TWISTED,   // corners two and three swapped: edges cross
      REGION_NO_BAND,   // floor above ceiling, nothing may be kept
      REGION_WIDE,      // corners and band at the extremes of their ranges
      REGION_WILD       // fully random corners and vehicle position
   } region_kind_type;

   typedef struct {
      lpqrg_pkg::coord_type  x;
      lpqrg_pkg::coord_type  y;
      lpqrg_pkg::height_type z;
      lpqrg_pkg::index_type  idx;
   } lidar_point_type;

   typedef struct packed {
      logic                  keep;
      lpqrg_pkg::coord_type  lx;
      lpqrg_pkg::coord_type  ly;
      lpqrg_pkg::height_type z;
      lpqrg_pkg::index_type  idx;
   } gate_result_type;

   logic                                    clock;
   logic                                    reset = 1'b1;
   logic [lpqrg_pkg::IN_TDATA_BITS-1:0]     req_tdata = '0;
   logic                                    req_tvalid = 1'b0;
   logic                                    req_tready;
   logic [lpqrg_pkg::OUT_TDATA_BITS-1:0]    rsp_tdata;
   logic                                    rsp_tuser;
   logic                                    rsp_tvalid;
   logic                                    rsp_tready = 1'b0;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [lpqrg_pkg::CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [lpqrg_pkg::CSR_DATA_BITS-1:0]     csr_data = '0;

   // Our own copy of the region setup, updated on each accepted register write
   lpqrg_pkg::coord_type  roi_x [4];
   lpqrg_pkg::coord_type  roi_y [4];
   lpqrg_pkg::height_type band_lo;
   lpqrg_pkg::height_type band_hi;
   lpqrg_pkg::coord_type  veh_x;
   lpqrg_pkg::coord_type  veh_y;

   lidar_point_type  point_q [$];        // points waiting to be driven
   gate_result_type  gate_result_q [$];  // predicted results, oldest first
   lidar_point_type  cur_point;          // word currently on req_tdata
   int               gap_left;
   int               stall_left;
   bit               gaps_on;
   bit               stalls_on;
   int unsigned      fault_count;
   int unsigned      results_seen;
   int unsigned      cycle_count;

   lidar_point_quad_roi_gate_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- helpers

   // Idle length for either side: mostly none, some short, a few long
   function automatic int idle_len(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Uniform value in [lo, hi]; spans stay far below 2**64
   function automatic longint rand_between(longint lo, longint hi);
      longint unsigned span;
      longint unsigned r;
      span = hi - lo + 1;
      r = {$urandom, $urandom};
      return lo + longint'(r % span);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Register layout for a point-valued register: x low word, y high word
   function automatic logic [lpqrg_pkg::CSR_DATA_BITS-1:0] xy_word(longint x, longint y);
      return {y[31:0], x[31:0]};
   endfunction

   // Axis-aligned bounding box of the four corners
   function automatic void box_limits(output longint lo_x, output longint hi_x,
                                      output longint lo_y, output longint hi_y);
      lo_x = roi_x[0];
      hi_x = roi_x[0];
      lo_y = roi_y[0];
      hi_y = roi_y[0];
      for (int k = 1; k < 4; k++) begin
         if (roi_x[k] < lo_x) lo_x = roi_x[k];
         if (roi_x[k] > hi_x) hi_x = roi_x[k];
         if (roi_y[k] < lo_y) lo_y = roi_y[k];
         if (roi_y[k] > hi_y) hi_y = roi_y[k];
      end
   endfunction

   // Expected gate result for one point under the current region setup
   function automatic gate_result_type gate_point(lidar_point_type p);
      gate_result_type r;
      longint lo_x, hi_x, lo_y, hi_y;
      logic signed [127:0] rel_x, rel_y, edge_dx, edge_dy, cross_prod;
      bit saw_neg;
      bit saw_pos;
      int j;
      box_limits(lo_x, hi_x, lo_y, hi_y);
      r.keep = p.x >= lo_x && p.x <= hi_x && p.y >= lo_y && p.y <= hi_y &&
               p.z >= band_lo && p.z <= band_hi;
      // Exact edge cross products; zero sides with either sign
      saw_neg = 1'b0;
      saw_pos = 1'b0;
      for (int i = 0; i < 4; i++) begin
         j = (i + 1) % 4;
         rel_x      = longint'(p.x) - longint'(roi_x[i]);
         rel_y      = longint'(p.y) - longint'(roi_y[i]);
         edge_dx    = longint'(roi_x[j]) - longint'(roi_x[i]);
         edge_dy    = longint'(roi_y[j]) - longint'(roi_y[i]);
         cross_prod = rel_x * edge_dy - rel_y * edge_dx;
         if (cross_prod < 0) saw_neg = 1'b1;
         if (cross_prod > 0) saw_pos = 1'b1;
      end
      if (saw_neg && saw_pos) r.keep = 1'b0;
      r.lx  = lpqrg_pkg::coord_type'(clamp(longint'(p.x) - longint'(veh_x),
                                           COORD_MIN, COORD_MAX));
      r.ly  = lpqrg_pkg::coord_type'(clamp(longint'(p.y) - longint'(veh_y),
                                           COORD_MIN, COORD_MAX));
      r.z   = p.z;
      r.idx = p.idx;
      return r;
   endfunction

   task automatic note_fault(string msg);
      if (fault_count < MAX_REPORTS) $display("mismatch: %s", msg);
      fault_count++;
   endtask

   // ---------------------------------------------------------------- point driver

   // Present words from point_q; predict each one at the edge where it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            gate_result_q.insert(gate_result_q.size(), gate_point(cur_point));
            gap_left = idle_len(gaps_on);
         end
         // Hold the word while it is stalled; otherwise advance or idle
         if (!req_tvalid || req_tready) begin
            if (gap_left == 0 && point_q.size() != 0) begin
               cur_point = point_q.pop_front();
               req_tdata <= lpqrg_pkg::IN_TDATA_BITS'({cur_point.idx, cur_point.z,
                                                       cur_point.y, cur_point.x});
               req_tvalid <= 1'b1;
            end else begin
               if (gap_left != 0) gap_left--;
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor

   always @(posedge clock) begin
      gate_result_type want;
      gate_result_type got;
      string bad;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.keep = rsp_tuser;
            got.lx   = rsp_tdata[0 +: lpqrg_pkg::COORD_BITS];
            got.ly   = rsp_tdata[lpqrg_pkg::COORD_BITS +: lpqrg_pkg::COORD_BITS];
            got.z    = rsp_tdata[2*lpqrg_pkg::COORD_BITS +: lpqrg_pkg::HEIGHT_BITS];
            got.idx  = rsp_tdata[2*lpqrg_pkg::COORD_BITS+lpqrg_pkg::HEIGHT_BITS +:
                                 lpqrg_pkg::INDEX_BITS];
            if (gate_result_q.size() == 0) begin
               note_fault($sformatf("result word %0d arrived with nothing pending",
                                    results_seen));
            end else begin
               want = gate_result_q.pop_front();
               bad = "";
               if (got.keep !== want.keep) bad = {bad, " keep"};
               if (got.lx !== want.lx) bad = {bad, " local_x"};
               if (got.ly !== want.ly) bad = {bad, " local_y"};
               if (got.z !== want.z) bad = {bad, " height_out"};
               if (got.idx !== want.idx) bad = {bad, " index_out"};
               if (bad != "")
                  note_fault($sformatf({"word %0d bad:%s; expected keep=%0b x=%0d y=%0d ",
                     "z=%0d idx=%0h, got keep=%0b x=%0d y=%0d z=%0d idx=%0h"},
                     results_seen, bad, want.keep, $signed(want.lx), $signed(want.ly),
                     $signed(want.z), want.idx, got.keep, $signed(got.lx),
                     $signed(got.ly), $signed(got.z), got.idx));
            end
            results_seen++;
         end
         // Back-pressure: drop ready for a random stretch after each ready cycle
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = idle_len(stalls_on);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // One register write; mirror it into the predictor at the handshake edge
   task automatic write_reg(logic [lpqrg_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [lpqrg_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         lpqrg_pkg::REG_CORNER_ONE, lpqrg_pkg::REG_CORNER_TWO,
         lpqrg_pkg::REG_CORNER_THREE, lpqrg_pkg::REG_CORNER_FOUR: begin
            roi_x[idx[1:0]] = val[31:0];
            roi_y[idx[1:0]] = val[63:32];
         end
         lpqrg_pkg::REG_Z_FLOOR:     band_lo = val[lpqrg_pkg::HEIGHT_BITS-1:0];
         lpqrg_pkg::REG_Z_CEILING:   band_hi = val[lpqrg_pkg::HEIGHT_BITS-1:0];
         lpqrg_pkg::REG_VEHICLE_POS: begin
            veh_x = val[31:0];
            veh_y = val[63:32];
         end
         default: ;  // unmapped index: no effect
      endcase
   endtask

   task automatic send_point(longint x, longint y, longint z, longint idx);
      lidar_point_type p;
      p.x   = lpqrg_pkg::coord_type'(x);
      p.y   = lpqrg_pkg::coord_type'(y);
      p.z   = lpqrg_pkg::height_type'(z);
      p.idx = lpqrg_pkg::index_type'(idx);
      point_q.insert(point_q.size(), p);
   endtask

   // Block until every queued word is out and every result is back, then let the
   // pipeline settle before the next register write.
   task automatic wait_idle();
      do @(negedge clock);
      while (point_q.size() != 0 || req_tvalid || gate_result_q.size() != 0);
      repeat (lpqrg_pkg::PIPE_DEPTH + 2) @(negedge clock);
   endtask

   // Random point aimed at the current region: corners, edge midpoints, the box with
   // a margin around it, and some full-range words for bit coverage and saturation.
   task automatic send_random_point();
      longint lo_x, hi_x, lo_y, hi_y, mx, my, zlo, zhi, x, y, z;
      int r;
      int k;
      box_limits(lo_x, hi_x, lo_y, hi_y);
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 3);
      if (r < 10) begin
         x = roi_x[k];
         y = roi_y[k];
      end else if (r < 18) begin
         x = (longint'(roi_x[k]) + longint'(roi_x[(k + 1) % 4])) / 2;
         y = (longint'(roi_y[k]) + longint'(roi_y[(k + 1) % 4])) / 2;
      end else if (r < 75) begin
         mx = (hi_x - lo_x) / 8 + 2;
         my = (hi_y - lo_y) / 8 + 2;
         x = clamp(rand_between(lo_x - mx, hi_x + mx), COORD_MIN, COORD_MAX);
         y = clamp(rand_between(lo_y - my, hi_y + my), COORD_MIN, COORD_MAX);
      end else begin
         x = longint'(lpqrg_pkg::coord_type'($urandom));
         y = longint'(lpqrg_pkg::coord_type'($urandom));
      end
      zlo = (band_lo < band_hi ? band_lo : band_hi) - 3;
      zhi = (band_lo < band_hi ? band_hi : band_lo) + 3;
      if ($urandom_range(0, 99) < 80)
         z = clamp(rand_between(zlo, zhi), HEIGHT_MIN, HEIGHT_MAX);
      else
         z = longint'(lpqrg_pkg::height_type'($urandom));
      send_point(x, y, z, $urandom);
   endtask

   // Write a fresh region of the given kind through every register
   task automatic setup_region(region_kind_type kind);
      longint qx [4];
      longint qy [4];
      longint cx, cy, t, floor_z, ceil_z;
      logic [lpqrg_pkg::CSR_DATA_BITS-1:0] veh;
      cx = rand_between(-20000, 20000);
      cy = rand_between(-20000, 20000);
      // One corner per quadrant around the center, counter-clockwise
      qx[0] = cx + rand_between(50, 8000);  qy[0] = cy + rand_between(50, 8000);
      qx[1] = cx - rand_between(50, 8000);  qy[1] = cy + rand_between(50, 8000);
      qx[2] = cx - rand_between(50, 8000);  qy[2] = cy - rand_between(50, 8000);
      qx[3] = cx + rand_between(50, 8000);  qy[3] = cy - rand_between(50, 8000);
      floor_z = rand_between(-300, 100);
      ceil_z  = floor_z + rand_between(0, 400);
      veh = xy_word(cx + rand_between(-30000, 30000), cy + rand_between(-30000, 30000));
      case (kind)
         REGION_CW: begin
            t = qx[1]; qx[1] = qx[3]; qx[3] = t;
            t = qy[1]; qy[1] = qy[3]; qy[3] = t;
         end
         REGION_TWISTED: begin
            t = qx[1]; qx[1] = qx[2]; qx[2] = t;
            t = qy[1]; qy[1] = qy[2]; qy[2] = t;
         end
         REGION_NO_BAND: ceil_z = floor_z - rand_between(1, 50);
         REGION_WIDE: begin
            qx = '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX};
            qy = '{COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN};
            floor_z = HEIGHT_MIN;
            ceil_z  = HEIGHT_MAX;
            veh = xy_word(COORD_MIN, COORD_MAX);
         end
         REGION_WILD: begin
            for (int k = 0; k < 4; k++) begin
               qx[k] = $urandom;
               qy[k] = $urandom;
            end
            floor_z = rand_between(HEIGHT_MIN, 0);
            ceil_z  = rand_between(0, HEIGHT_MAX);
            veh = {$urandom, $urandom};
         end
         default: ;
      endcase
      for (int k = 0; k < 4; k++)
         write_reg(lpqrg_pkg::CSR_INDEX_BITS'(lpqrg_pkg::REG_CORNER_ONE + k),
                   xy_word(qx[k], qy[k]));
      // Junk above the 16-bit height must be dropped
      write_reg(lpqrg_pkg::REG_Z_FLOOR, {$urandom, 16'($urandom), 16'(floor_z)});
      write_reg(lpqrg_pkg::REG_Z_CEILING, {$urandom, 16'($urandom), 16'(ceil_z)});
      write_reg(lpqrg_pkg::REG_VEHICLE_POS, veh);
      if ($urandom_range(0, 1)) write_reg(REG_UNUSED, {$urandom, $urandom});
   endtask

   initial begin
      region_kind_type plan [7];
      for (int k = 0; k < 4; k++) begin
         roi_x[k] = '0;
         roi_y[k] = '0;
      end
      band_lo = '0;
      band_hi = '0;
      veh_x = '0;
      veh_y = '0;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset setup: all corners at the origin, band [0, 0]. Only the origin at
      // height zero passes the degenerate shape.
      send_point(0, 0, 0, 0);
      send_point(0, 0, 0, INDEX_MAX);
      send_point(1, 0, 0, 5);
      send_point(0, 0, -1, 6);
      send_point(COORD_MAX, COORD_MIN, HEIGHT_MAX, INDEX_MAX);
      wait_idle();

      // Diamond, counter-clockwise; vehicle far out so extreme points saturate
      write_reg(lpqrg_pkg::REG_CORNER_ONE, xy_word(0, -1000));
      write_reg(lpqrg_pkg::REG_CORNER_TWO, xy_word(1000, 0));
      write_reg(lpqrg_pkg::REG_CORNER_THREE, xy_word(0, 1000));
      write_reg(lpqrg_pkg::REG_CORNER_FOUR, xy_word(-1000, 0));
      write_reg(lpqrg_pkg::REG_Z_FLOOR, 64'(-50));
      write_reg(lpqrg_pkg::REG_Z_CEILING, 64'(300));
      write_reg(lpqrg_pkg::REG_VEHICLE_POS, xy_word(-2000000000, 2000000000));
      gaps_on = 1'b1;
      stalls_on = 1'b1;
      @(negedge clock);
      send_point(0, 0, 0, 1);                   // center
      send_point(500, 500, 10, 2);              // on an edge
      send_point(600, 600, 10, 3);              // in the box, outside the diamond
      send_point(1000, 0, 300, 4);              // corner, at the ceiling
      send_point(1001, 0, 0, 5);                // just past the box
      send_point(0, 0, -50, 6);                 // at the floor
      send_point(0, 0, -51, 7);                 // below the floor
      send_point(0, 0, 301, 8);                 // above the ceiling
      send_point(0, -1000, 0, 9);               // first corner
      send_point(COORD_MAX, COORD_MIN, HEIGHT_MIN, 0);
      send_point(COORD_MIN, COORD_MAX, HEIGHT_MAX, INDEX_MAX);
      wait_idle();

      // Same diamond clockwise, plus a write to the unmapped index
      write_reg(lpqrg_pkg::REG_CORNER_TWO, xy_word(-1000, 0));
      write_reg(lpqrg_pkg::REG_CORNER_FOUR, xy_word(1000, 0));
      write_reg(REG_UNUSED, {lpqrg_pkg::CSR_DATA_BITS{1'b1}});
      @(negedge clock);
      send_point(0, 0, 0, 10);
      send_point(500, 500, 0, 11);
      send_point(600, 600, 0, 12);
      send_point(-999, 0, 0, 13);
      wait_idle();

      // Floor above ceiling: nothing passes
      write_reg(lpqrg_pkg::REG_Z_FLOOR, 64'(10));
      write_reg(lpqrg_pkg::REG_Z_CEILING, 64'(9));
      @(negedge clock);
      send_point(0, 0, 9, 14);
      send_point(0, 0, 10, 15);
      wait_idle();

      // Random phases, one region kind each; the first runs without idling
      plan = '{REGION_CCW, REGION_CW, REGION_TWISTED, REGION_NO_BAND,
               REGION_WIDE, REGION_WILD, REGION_CCW};
      for (int ph = 0; ph < 7; ph++) begin
         setup_region(plan[ph]);
         gaps_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
         stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
         @(negedge clock);
         repeat (86) send_random_point();
         wait_idle();
      end

      repeat (lpqrg_pkg::PIPE_DEPTH + 4) @(posedge clock);
      if (gate_result_q.size() != 0)
         note_fault($sformatf("%0d results never arrived", gate_result_q.size()));
      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
